@@ rtl/tocb_pkg.sv @@
// Shared types, constants and codes for the timed output channel bank.
package tocb_pkg;

  // Channels that exist in hardware; the masks carry eight bits.
  localparam int NUM_CHANNELS = 8;
  localparam int NUM_SLOTS    = 8;
  localparam int MASK_W       = 8;
  localparam int CH_W         = 3;
  localparam int DUR_W        = 10;
  localparam int TICK_W       = 26;
  localparam int REM_W        = 16;
  localparam int ACT_W        = 3;

  // Channels that can take part in commands at all.
  localparam logic [MASK_W-1:0] USE_LIMIT =
    (NUM_CHANNELS >= NUM_SLOTS) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_CHANNELS) - 1);

  // Millisecond ticks per minute.
  localparam int TICKS_PER_MIN = 60 * 1000;

  // Ticks to seconds: drop three bits, then divide by 125 with a reciprocal.
  localparam int DIV_PRE   = 3;
  localparam int Y_W       = TICK_W - DIV_PRE;
  localparam int MAGIC_W   = 24;
  localparam int DIV_SHIFT = 30;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = MAGIC_W'(8589935);
  localparam int PROD_W    = Y_W + MAGIC_W;

  // Command queue depth between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input action codes.
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ON     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_OFF    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TOGGLE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STATUS = 3'd4;

  // Result kinds.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Register index, taken from address bit 2.
  localparam logic REG_PRESENT  = 1'b0;
  localparam logic REG_INVERTED = 1'b1;

  // Decoded operation handed from front to back.
  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_TICK   = 3'd1,
    OP_ON     = 3'd2,
    OP_OFF    = 3'd3,
    OP_TOGGLE = 3'd4,
    OP_STATUS = 3'd5
  } op_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [CH_W-1:0]  channel;
    logic             all_channels;
    logic [DUR_W-1:0] duration_min;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [MASK_W-1:0] pin_levels;
    logic [MASK_W-1:0] on_mask;
    logic [MASK_W-1:0] expired_mask;
    logic [CH_W-1:0]   entry_channel;
    logic [REM_W-1:0]  secs_left;
    logic              last;
  } out_item_t;

  // Classified command: operation, channels it touches, timer load value.
  typedef struct packed {
    op_t               op;
    logic [MASK_W-1:0] target;
    logic [TICK_W-1:0] ticks;
  } cmd_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic              present_wr;
    logic [MASK_W-1:0] present_wdata;
    logic [MASK_W-1:0] inverted;
  } cfg_ctl_t;

endpackage

@@ rtl/tocb_front.sv @@
// Front end: classifies an accepted command and computes its timer load value.
module tocb_front import tocb_pkg::*; (
  input  in_item_t          item,
  input  logic [MASK_W-1:0] present_mask,
  output cmd_t              cmd
);

  logic [MASK_W-1:0] use_mask;
  logic [MASK_W-1:0] named;

  assign use_mask = present_mask & USE_LIMIT;
  assign named    = (MASK_W'(1) << item.channel) & use_mask;

  // Map the action to an operation and the set of channels it touches.
  always_comb begin
    cmd.op     = OP_NOP;
    cmd.target = '0;
    cmd.ticks  = TICK_W'(TICK_W'(item.duration_min) * TICK_W'(TICKS_PER_MIN));
    unique case (item.action)
      ACT_TICK: begin
        cmd.op = OP_TICK;
      end
      ACT_ON: begin
        cmd.op     = OP_ON;
        cmd.target = item.all_channels ? use_mask : named;
      end
      ACT_OFF: begin
        cmd.op     = OP_OFF;
        cmd.target = item.all_channels ? use_mask : named;
      end
      ACT_TOGGLE: begin
        cmd.op     = OP_TOGGLE;
        cmd.target = named;
      end
      ACT_STATUS: begin
        cmd.op     = OP_STATUS;
        cmd.target = use_mask;
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

@@ rtl/tocb_queue.sv @@
// Short command queue that decouples the front end from the back end.
module tocb_queue import tocb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

@@ rtl/tocb_back.sv @@
// Back end: owns channel state, executes commands and emits results.
module tocb_back import tocb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_ctl_t  cfg,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_res
);

  typedef enum logic [1:0] {
    BE_IDLE = 2'b01,
    BE_STAT = 2'b10
  } be_state_t;

  be_state_t         state_r, state_nxt;
  logic [MASK_W-1:0] on_r, on_nxt;
  logic [TICK_W-1:0] ticks_r [NUM_SLOTS];
  logic [TICK_W-1:0] ticks_nxt [NUM_SLOTS];
  logic [CH_W-1:0]   idx_r, idx_nxt;
  logic [MASK_W-1:0] stat_mask_r, stat_mask_nxt;
  logic [MASK_W-1:0] expired;
  logic              upd_fire;

  // Status pipeline stage: scaled ticks times reciprocal.
  logic              p_valid_r, p_valid_nxt;
  logic [CH_W-1:0]   p_ch_r;
  logic              p_last_r, p_last_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [MASK_W-1:0] higher;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  // Command execution and status scan control.
  always_comb begin
    state_nxt     = state_r;
    on_nxt        = on_r;
    ticks_nxt     = ticks_r;
    idx_nxt       = idx_r;
    stat_mask_nxt = stat_mask_r;
    expired       = '0;
    upd_fire      = 1'b0;
    q_pop         = 1'b0;
    if (cfg.present_wr) begin
      // Channels dropped from the present set switch off and lose their timer.
      for (int c = 0; c < NUM_SLOTS; c++) begin
        if (!cfg.present_wdata[c]) begin
          on_nxt[c]    = 1'b0;
          ticks_nxt[c] = '0;
        end
      end
    end else begin
      unique case (state_r)
        BE_IDLE: begin
          if (!q_empty && !p_valid_r) begin
            q_pop = 1'b1;
            unique case (q_cmd.op)
              OP_TICK: begin
                upd_fire = 1'b1;
                for (int c = 0; c < NUM_SLOTS; c++) begin
                  if (on_r[c] && ticks_r[c] != '0) begin
                    ticks_nxt[c] = ticks_r[c] - 1'b1;
                    if (ticks_r[c] == TICK_W'(1)) begin
                      on_nxt[c]  = 1'b0;
                      expired[c] = 1'b1;
                    end
                  end
                end
              end
              OP_ON: begin
                upd_fire = 1'b1;
                for (int c = 0; c < NUM_SLOTS; c++) begin
                  if (q_cmd.target[c]) begin
                    on_nxt[c]    = 1'b1;
                    ticks_nxt[c] = q_cmd.ticks;
                  end
                end
              end
              OP_OFF: begin
                upd_fire = 1'b1;
                for (int c = 0; c < NUM_SLOTS; c++) begin
                  if (q_cmd.target[c]) begin
                    on_nxt[c]    = 1'b0;
                    ticks_nxt[c] = '0;
                  end
                end
              end
              OP_TOGGLE: begin
                upd_fire = 1'b1;
                for (int c = 0; c < NUM_SLOTS; c++) begin
                  if (q_cmd.target[c]) begin
                    on_nxt[c]    = !on_r[c];
                    ticks_nxt[c] = on_r[c] ? '0 : q_cmd.ticks;
                  end
                end
              end
              OP_STATUS: begin
                // An empty present set gives no status entries at all.
                if (q_cmd.target != '0) begin
                  state_nxt     = BE_STAT;
                  idx_nxt       = '0;
                  stat_mask_nxt = q_cmd.target;
                end
              end
              default: begin
                upd_fire = 1'b1;
              end
            endcase
          end
        end
        BE_STAT: begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == CH_W'(NUM_SLOTS - 1)) begin
            state_nxt = BE_IDLE;
          end
        end
        default: begin
          state_nxt = BE_IDLE;
        end
      endcase
    end
  end

  // A status entry is the last one when no present channel lies above it.
  assign higher      = stat_mask_r >> idx_r;
  assign p_last_nxt  = (higher[MASK_W-1:1] == '0);
  assign p_valid_nxt = (state_r == BE_STAT) && stat_mask_r[idx_r];

  // Result register: a status entry from the pipeline or an update.
  always_comb begin
    out_valid_nxt = p_valid_r || upd_fire;
    out_nxt       = out_r;
    if (p_valid_r) begin
      out_nxt.kind          = KIND_STATUS;
      out_nxt.pin_levels    = on_r ^ cfg.inverted;
      out_nxt.on_mask       = on_r;
      out_nxt.expired_mask  = '0;
      out_nxt.entry_channel = p_ch_r;
      out_nxt.secs_left     = prod_r[DIV_SHIFT +: REM_W];
      out_nxt.last          = p_last_r;
    end else if (upd_fire) begin
      out_nxt.kind          = KIND_UPDATE;
      out_nxt.pin_levels    = on_nxt ^ cfg.inverted;
      out_nxt.on_mask       = on_nxt;
      out_nxt.expired_mask  = expired;
      out_nxt.entry_channel = '0;
      out_nxt.secs_left     = '0;
      out_nxt.last          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BE_IDLE;
      on_r        <= '0;
      idx_r       <= '0;
      stat_mask_r <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_SLOTS; c++) begin
        ticks_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      on_r        <= on_nxt;
      idx_r       <= idx_nxt;
      stat_mask_r <= stat_mask_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

  // Payload registers of the status stage and the result.
  always_ff @(posedge clk) begin
    p_ch_r   <= idx_r;
    p_last_r <= p_last_nxt;
    prod_r   <= PROD_W'(ticks_r[idx_r][TICK_W-1:DIV_PRE]) * PROD_W'(DIV_MAGIC);
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

@@ rtl/timed_output_channel_bank.sv @@
// Top level of the timed output channel bank: register port, front, queue and back.
//
// A command is taken when start is high and busy is low; busy rises only while the
// two-entry command queue is full. Tick, on, off, toggle and unused codes each give
// one update result, registered once the back end pops it; the back end retires one
// such command per cycle unless a status scan or present-mask write holds it. A status
// query walks all eight channel slots one per cycle, pausing for present-mask writes,
// and emits one entry per present channel through a one-stage reciprocal multiplier.
// Results appear for one cycle with out_valid and cannot be held off; pin levels
// always use the inverted mask in force when the result is formed.
module timed_output_channel_bank import tocb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_cmd,
  output logic        out_valid,
  output out_item_t   out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [MASK_W-1:0] present_r, present_nxt;
  logic [MASK_W-1:0] inverted_r, inverted_nxt;
  logic              cfg_wr;
  logic              q_full, q_empty, q_pop, q_push;
  cmd_t              front_cmd, q_cmd;
  cfg_ctl_t          cfg;

  // Register write transfer.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    present_nxt  = present_r;
    inverted_nxt = inverted_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_PRESENT:  present_nxt  = pwdata[MASK_W-1:0];
        REG_INVERTED: inverted_nxt = pwdata[MASK_W-1:0];
        default:      present_nxt  = present_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      inverted_r <= '0;
    end else begin
      present_r  <= present_nxt;
      inverted_r <= inverted_nxt;
    end
  end

  // Register read data.
  assign prdata = {{(32 - MASK_W){1'b0}}, (paddr[2] == REG_INVERTED) ? inverted_r : present_r};

  assign cfg.present_wr    = cfg_wr && (paddr[2] == REG_PRESENT);
  assign cfg.present_wdata = pwdata[MASK_W-1:0];
  assign cfg.inverted      = inverted_r;

  // Command transfer into the queue.
  assign busy   = q_full;
  assign q_push = start && !q_full;

  tocb_front u_front (
    .item         (in_cmd),
    .present_mask (present_r),
    .cmd          (front_cmd)
  );

  tocb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (front_cmd),
    .pop   (q_pop),
    .dout  (q_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  tocb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

@@ rtl/tocb_checker.sv @@
// Port-level checker for the timed output channel bank, bound to the top level.
module tocb_checker import tocb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input out_item_t out_res
);

  // No result is presented in the cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // Status entries never report expiry.
  a_status_no_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.kind == KIND_STATUS) |-> out_res.expired_mask == '0)
    else $error("status entry carries an expiry mask");

  // An update is a single final result with no timer value.
  a_update_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.kind == KIND_UPDATE) |->
      (out_res.last && out_res.secs_left == '0 && out_res.entry_channel == '0))
    else $error("malformed update result");

  // An expired channel is off in the same update.
  a_expired_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.expired_mask & out_res.on_mask) == '0)
    else $error("expired channel still on");

endmodule

bind timed_output_channel_bank tocb_checker u_tocb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_res   (out_res)
);
